// File: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// Stabiliser levelling controller package
// Transaction types, register indexes, drive constants and shared structs.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned AngleW = 21;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DriveW = 14;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned Legs   = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SET_POINT    = 2'd0,
    CFG_TOLERANCE    = 2'd1,
    CFG_DWELL_TIME   = 2'd2,
    CFG_UNLEVEL_HOLD = 2'd3
  } cfg_idx_e;

  localparam logic [AngleW-1:0] SetPointRst    = AngleW'(0);
  localparam logic [AngleW-1:0] ToleranceRst   = AngleW'(100);
  localparam logic [TimeW-1:0]  DwellTimeRst   = TimeW'(2000);
  localparam logic [TimeW-1:0]  UnlevelHoldRst = TimeW'(10000);

  // Leg drives are the negated speeds.
  localparam logic signed [DriveW-1:0] DrvZero     = 14'sd0;
  localparam logic signed [DriveW-1:0] DrvRaise    = 14'sd4000;
  localparam logic signed [DriveW-1:0] DrvSeekHigh = -14'sd8000;
  localparam logic signed [DriveW-1:0] DrvSeekLow  = -14'sd7500;
  localparam logic signed [DriveW-1:0] DrvTrimHigh = -14'sd5000;
  localparam logic signed [DriveW-1:0] DrvTrimLow  = 14'sd3800;

  typedef struct packed {
    logic              command;
    logic              restart;
    logic [Legs-1:0]   lights;
    logic [31:0]       x_frame;
    logic [31:0]       y_frame;
    logic [TimeW-1:0]  now;
  } in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_s0;
    logic signed [DriveW-1:0] drive_s1;
    logic signed [DriveW-1:0] drive_s2;
    logic signed [DriveW-1:0] drive_s3;
    logic                     level_reached;
    logic                     ready_res;
  } out_t;

  // Tilt summary handed from the tilt evaluator to the control logic.
  typedef struct packed {
    logic            in_window; // both errors inside the tolerance window
    logic            outside;   // either error beyond twice the tolerance
    logic [Legs-1:0] high;      // legs that take the high speed of the pattern
  } tilt_info_t;

endpackage

// File: hdl/slc_tilt.sv
// ----------------------------------------------------------------------------
// Tilt evaluator
// Decodes both tilt frames, forms the errors against the set point and
// derives the window flags and the high/low leg pattern.
// ----------------------------------------------------------------------------
module slc_tilt import slc_pkg::*; (
  input  logic [31:0]       x_frame_i,
  input  logic [31:0]       y_frame_i,
  input  logic [AngleW-1:0] set_point_i,
  input  logic [AngleW-1:0] tolerance_i,
  output tilt_info_t        info_o
);

  // Byte weights are 4096, 256, 16 and 1.
  function automatic logic [AngleW-1:0] decode_angle(input logic [31:0] frame);
    logic [AngleW-1:0] acc;
    acc = AngleW'({frame[31:24], 12'd0}) + AngleW'({frame[23:16], 8'd0})
        + AngleW'({frame[15:8], 4'd0}) + AngleW'(frame[7:0]);
    return acc;
  endfunction

  logic [AngleW-1:0]        x_ang, y_ang;
  logic signed [AngleW:0]   x_err, y_err;
  logic [AngleW-1:0]        x_mag, y_mag;
  logic [AngleW:0]          tol2;
  logic                     x_pos, y_pos, y_major;

  always_comb begin
    x_ang = decode_angle(x_frame_i);
    y_ang = decode_angle(y_frame_i);
    x_err = $signed({1'b0, x_ang}) - $signed({1'b0, set_point_i});
    y_err = $signed({1'b0, y_ang}) - $signed({1'b0, set_point_i});
    x_mag = x_err[AngleW] ? AngleW'(-x_err) : x_err[AngleW-1:0];
    y_mag = y_err[AngleW] ? AngleW'(-y_err) : y_err[AngleW-1:0];
    x_pos = !x_err[AngleW] && (x_err != '0);
    y_pos = !y_err[AngleW] && (y_err != '0);
    tol2  = {tolerance_i, 1'b0};
    y_major = y_mag > x_mag;

    info_o.in_window = (x_mag <= tolerance_i) && (y_mag <= tolerance_i);
    info_o.outside   = ({1'b0, x_mag} > tol2) || ({1'b0, y_mag} > tol2);

    // Bit k set means leg k takes the high speed.
    if (y_major) begin
      info_o.high = y_pos ? 4'b0011 : 4'b1100;
    end else begin
      info_o.high = x_pos ? 4'b0110 : 4'b1001;
    end
  end

endmodule

// File: hdl/stabiliser_levelling_controller.sv
// ----------------------------------------------------------------------------
// Stabiliser levelling controller
// Turns ground lights, tilt frames and a timestamp into four leg drives.
// ----------------------------------------------------------------------------
// Path: an accepted input transaction passes the input register, one pass of
// logic and the result register before it is offered as a result.
// Throughput: one transaction per cycle unless results stall; the input
// and result registers are the only stages, and control state moves at once.
// Reset: rst_ni clears both valid flags, loads the register reset values and
// clears the level state, the leg timers and the remembered lights.
// ----------------------------------------------------------------------------
module stabiliser_levelling_controller import slc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  // Result channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  // Configuration write port
  input  logic            cfg_we_i,
  input  cfg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Write only while the block is idle (unenforced).
  // --------------------------------------------------------------------------
  logic [AngleW-1:0] set_point_q, tolerance_q;
  logic [TimeW-1:0]  dwell_time_q, unlevel_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_point_q    <= SetPointRst;
      tolerance_q    <= ToleranceRst;
      dwell_time_q   <= DwellTimeRst;
      unlevel_hold_q <= UnlevelHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_POINT:    set_point_q    <= cfg_data_i[AngleW-1:0];
        CFG_TOLERANCE:    tolerance_q    <= cfg_data_i[AngleW-1:0];
        CFG_DWELL_TIME:   dwell_time_q   <= cfg_data_i[TimeW-1:0];
        CFG_UNLEVEL_HOLD: unlevel_hold_q <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register moves into the result register whenever
  // the result register is empty or its transaction is being taken, so the
  // input side only stalls while a finished result is held up downstream.
  // --------------------------------------------------------------------------
  logic s_valid_q, out_valid_q;
  in_t  s_item_q;
  logic s_adv, in_acc, out_acc;

  assign s_adv      = s_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !s_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s_valid_q <= 1'b1;
      end else if (s_adv) begin
        s_valid_q <= 1'b0;
      end
      if (s_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_item_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Tilt evaluation on the registered transaction.
  // --------------------------------------------------------------------------
  tilt_info_t tilt;

  slc_tilt u_tilt (
    .x_frame_i   (s_item_q.x_frame),
    .y_frame_i   (s_item_q.y_frame),
    .set_point_i (set_point_q),
    .tolerance_i (tolerance_q),
    .info_o      (tilt)
  );

  // --------------------------------------------------------------------------
  // Control state. The "now level" and "was level" bits always end a step
  // equal, so a single level bit carries both. The latest-time values are
  // only ever compared against their start times, so the elapsed time is
  // formed directly from the current timestamp instead of being stored.
  // --------------------------------------------------------------------------
  logic                   lvl_q, lvl_d;
  logic                   flag_q, flag_d;
  logic [TimeW-1:0]       lstart_q, lstart_d;
  logic [Legs-1:0]        prior_q, prior_d;
  logic [TimeW-1:0]       off_start_q [Legs];
  logic [TimeW-1:0]       off_start_d [Legs];
  logic signed [DriveW-1:0] drive [Legs];
  logic                   ready;

  always_comb begin
    logic             was_lvl;
    logic             now_lvl;
    logic             stop;
    logic [TimeW-1:0] ls;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] off_elapsed;

    lvl_d    = lvl_q;
    flag_d   = flag_q;
    lstart_d = lstart_q;
    prior_d  = prior_q;
    for (int i = 0; i < Legs; i++) begin
      off_start_d[i] = off_start_q[i];
      drive[i]       = DrvZero;
    end
    ready       = (s_item_q.lights == '1);
    was_lvl     = 1'b0;
    now_lvl     = 1'b0;
    stop        = 1'b0;
    ls          = '0;
    elapsed     = '0;
    off_elapsed = '0;

    if (s_item_q.command) begin
      // Unlevel: raise every leg; a leg that just lost its light keeps
      // rising until the hold time has passed.
      for (int i = 0; i < Legs; i++) begin
        off_elapsed = s_item_q.now - off_start_q[i];
        if (s_item_q.lights[i]) begin
          drive[i] = DrvRaise;
        end else if (prior_q[i]) begin
          off_start_d[i] = s_item_q.now;
          drive[i]       = DrvRaise;
        end else begin
          drive[i] = (off_elapsed < unlevel_hold_q) ? DrvRaise : DrvZero;
        end
      end
      prior_d = s_item_q.lights;
    end else if (!ready) begin
      // Seek ground: lower every unlit leg, lit legs hold still.
      for (int i = 0; i < Legs; i++) begin
        if (!s_item_q.lights[i]) begin
          drive[i] = tilt.high[i] ? DrvSeekHigh : DrvSeekLow;
        end
      end
    end else begin
      // All legs down: track the window with hysteresis and a dwell timer.
      // A restart request wipes the level state and the leg timers first.
      if (s_item_q.restart) begin
        for (int i = 0; i < Legs; i++) begin
          off_start_d[i] = '0;
        end
      end
      was_lvl = s_item_q.restart ? 1'b0 : lvl_q;
      ls      = s_item_q.restart ? '0 : lstart_q;
      now_lvl = (tilt.in_window || was_lvl) && !(was_lvl && tilt.outside);
      elapsed = s_item_q.now - ls;
      lstart_d = (now_lvl && !was_lvl) ? s_item_q.now : ls;
      flag_d   = now_lvl && was_lvl && (elapsed > dwell_time_q);
      lvl_d    = now_lvl;
      stop     = flag_d || tilt.in_window;
      if (!stop) begin
        for (int i = 0; i < Legs; i++) begin
          drive[i] = tilt.high[i] ? DrvTrimHigh : DrvTrimLow;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= 1'b0;
      flag_q   <= 1'b0;
      lstart_q <= '0;
      prior_q  <= '0;
      for (int i = 0; i < Legs; i++) begin
        off_start_q[i] <= '0;
      end
    end else if (s_adv) begin
      lvl_q    <= lvl_d;
      flag_q   <= flag_d;
      lstart_q <= lstart_d;
      prior_q  <= prior_d;
      for (int i = 0; i < Legs; i++) begin
        off_start_q[i] <= off_start_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. The level flag shows the value after this step, which
  // is the stored flag in any step that does not update it.
  // --------------------------------------------------------------------------
  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (s_adv) begin
      out_q.drive_s0      <= drive[0];
      out_q.drive_s1      <= drive[1];
      out_q.drive_s2      <= drive[2];
      out_q.drive_s3      <= drive[3];
      out_q.level_reached <= flag_d;
      out_q.ready_res     <= ready;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A level flag can only stand while the level bit is set.
  a_flag_needs_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> lvl_q)
    else $error("level flag set without level state");

  // The input side stalls only while a finished result is held downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Control state moves only when a transaction passes to the result stage.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_adv |=> ($stable(lvl_q) && $stable(flag_q) && $stable(prior_q)))
    else $error("control state changed without a transaction");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stabiliser levelling controller testbench
// Drives level and unlevel ticks through the valid/stall input channel with
// random source gaps and sink stalls, predicts every result transaction from
// an independent model of the levelling logic, and compares field by field.
// The run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import slc_pkg::*;

  localparam int          MaxAngle      = 1114095;
  localparam int          Phases        = 9;
  localparam int          WatchdogLimit = 400;

  // Leg drives are the negated speeds of the active pattern.
  localparam logic signed [DriveW-1:0] RaiseDrv = 14'sd4000;
  localparam logic signed [DriveW-1:0] SeekHigh = -14'sd8000;
  localparam logic signed [DriveW-1:0] SeekLow  = -14'sd7500;
  localparam logic signed [DriveW-1:0] TrimHigh = -14'sd5000;
  localparam logic signed [DriveW-1:0] TrimLow  = 14'sd3800;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_we_i    = 1'b0;
  cfg_idx_e        cfg_idx_i   = CFG_SET_POINT;
  logic [CfgW-1:0] cfg_data_i  = '0;

  stabiliser_levelling_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow of the configuration registers and of the controller state.
  // --------------------------------------------------------------------------
  logic [AngleW-1:0] cfg_set_point = 21'd0;
  logic [AngleW-1:0] cfg_tolerance = 21'd100;
  logic [TimeW-1:0]  cfg_dwell     = 32'd2000;
  logic [TimeW-1:0]  cfg_hold      = 32'd10000;

  bit                lvl_now, lvl_was, lvl_flag;
  logic [TimeW-1:0]  lvl_start, lvl_last;
  logic [Legs-1:0]   lights_before;
  logic [TimeW-1:0]  off_from [Legs];
  logic [TimeW-1:0]  off_last [Legs];

  in_t               tick_q[$];      // ticks waiting for the driver
  out_t              drive_fifo[$];  // predicted results, oldest first
  logic [TimeW-1:0]  clock_ms;       // running time base of the stimulus
  int                item_count;
  int                result_count;
  int                mismatch_count;
  int                src_idle_pct;
  int                snk_stall_pct;
  int                src_gap, snk_gap;
  bit                in_taken;
  int                idle_cycles;

  initial begin
    lvl_now       = 1'b0;
    lvl_was       = 1'b0;
    lvl_flag      = 1'b0;
    lvl_start     = '0;
    lvl_last      = '0;
    lights_before = '0;
    for (int k = 0; k < Legs; k++) begin
      off_from[k] = '0;
      off_last[k] = '0;
    end
  end

  function automatic int angle_of(logic [31:0] f);
    return int'(f[31:24]) * 4096 + int'(f[23:16]) * 256 + int'(f[15:8]) * 16 + int'(f[7:0]);
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Legs that take the high speed: the axis with the larger error wins, and
  // a tie goes to x.
  function automatic logic [Legs-1:0] high_legs(int xe, int ye);
    if (magnitude(ye) > magnitude(xe)) begin
      return (ye > 0) ? 4'b0011 : 4'b1100;
    end
    return (xe > 0) ? 4'b0110 : 4'b1001;
  endfunction

  // A restart clears the level tracking and the leg timers, but the
  // remembered lights survive.
  function automatic void clear_level();
    lvl_now   = 1'b0;
    lvl_was   = 1'b0;
    lvl_start = '0;
    lvl_last  = '0;
    lvl_flag  = 1'b0;
    for (int k = 0; k < Legs; k++) begin
      off_from[k] = '0;
      off_last[k] = '0;
    end
  endfunction

  // Works out the result of one accepted tick and advances the shadow state.
  function automatic out_t control_tick(in_t t);
    out_t                      r;
    logic signed [DriveW-1:0]  drv [Legs];
    logic [Legs-1:0]           hi;
    int                        xe, ye, tl;
    bit                        ready, in_window;
    ready = (t.lights == 4'hF);
    xe    = angle_of(t.x_frame) - int'(cfg_set_point);
    ye    = angle_of(t.y_frame) - int'(cfg_set_point);
    tl    = int'(cfg_tolerance);
    hi    = high_legs(xe, ye);
    for (int k = 0; k < Legs; k++) drv[k] = '0;

    if (t.command) begin
      // Unlevel: raise every leg; a leg whose light went off keeps rising
      // until its hold time has run out.
      for (int k = 0; k < Legs; k++) begin
        if (t.lights[k]) begin
          drv[k] = RaiseDrv;
        end else if (lights_before[k]) begin
          off_from[k] = t.now;
          off_last[k] = t.now;
          drv[k]      = RaiseDrv;
        end else begin
          off_last[k] = t.now;
          drv[k]      = ((off_last[k] - off_from[k]) < cfg_hold) ? RaiseDrv : '0;
        end
        lights_before[k] = t.lights[k];
      end
    end else if (!ready) begin
      // Seeking ground: only the unlit legs move.
      for (int k = 0; k < Legs; k++) begin
        drv[k] = t.lights[k] ? '0 : (hi[k] ? SeekHigh : SeekLow);
      end
    end else begin
      if (t.restart) clear_level();
      in_window = magnitude(xe) <= tl && magnitude(ye) <= tl;
      if (in_window) lvl_now = 1'b1;
      // Hysteresis: level is only lost beyond twice the tolerance.
      if (lvl_was && (magnitude(xe) > 2 * tl || magnitude(ye) > 2 * tl)) lvl_now = 1'b0;
      if (lvl_now && !lvl_was) begin
        lvl_start = t.now;
        lvl_last  = t.now;
      end else if (lvl_now) begin
        lvl_last = t.now;
      end else begin
        lvl_last = lvl_start;
      end
      lvl_flag = (lvl_last - lvl_start) > cfg_dwell;
      lvl_was  = lvl_now;
      if (!lvl_flag && !in_window) begin
        for (int k = 0; k < Legs; k++) drv[k] = hi[k] ? TrimHigh : TrimLow;
      end
    end

    r.drive_s0      = drv[0];
    r.drive_s1      = drv[1];
    r.drive_s2      = drv[2];
    r.drive_s3      = drv[3];
    r.level_reached = lvl_flag;
    r.ready_res     = ready;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Builds a tilt frame for an angle. The digit weights overlap, so the
  // split between bytes is randomized to use the non-canonical encodings too.
  function automatic logic [31:0] frame_of(int a);
    int b3, b2, b1, b0, r;
    b3 = a >> 12;
    if (b3 > 255) b3 = 255;
    r  = a - b3 * 4096;
    b2 = r >> 8;
    if (b2 > 255) b2 = 255;
    r -= b2 * 256;
    b1 = r >> 4;
    if (b1 > 255) b1 = 255;
    b0 = r - b1 * 16;
    if ($urandom_range(0, 1) && b3 > 0 && b2 <= 239) begin
      b3 -= 1;
      b2 += 16;
    end
    if ($urandom_range(0, 1) && b2 > 0 && b1 <= 239) begin
      b2 -= 1;
      b1 += 16;
    end
    if ($urandom_range(0, 1) && b1 > 0 && b0 <= 239) begin
      b1 -= 1;
      b0 += 16;
    end
    return {b3[7:0], b2[7:0], b1[7:0], b0[7:0]};
  endfunction

  // Band 0 is inside the tolerance window, band 1 the hysteresis band up to
  // just past twice the tolerance, band 2 clearly outside.
  function automatic logic [31:0] frame_at(int band);
    int tl, m, a;
    tl = int'(cfg_tolerance);
    case (band)
      0:       m = $urandom_range(0, tl);
      1:       m = $urandom_range(tl + 1, 2 * tl + 1);
      default: m = 2 * tl + 1 + $urandom_range(0, 5000);
    endcase
    a = int'(cfg_set_point) + ($urandom_range(0, 1) ? m : -m);
    if (a < 0) a = 0;
    if (a > MaxAngle) a = MaxAngle;
    return frame_of(a);
  endfunction

  task automatic add_tick(bit cmd, bit rs, logic [3:0] lt, logic [31:0] xf, logic [31:0] yf,
                          logic [31:0] tm);
    in_t t;
    t.command = cmd;
    t.restart = rs;
    t.lights  = lt;
    t.x_frame = xf;
    t.y_frame = yf;
    t.now     = tm;
    tick_q.push_back(t);
    item_count++;
  endtask

  // A levelling attempt: seek ground, approach, settle for longer than the
  // dwell, drift into the hysteresis band and finally fall out of level.
  task automatic level_episode();
    logic [31:0] step;
    bit          swap;
    if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
    repeat ($urandom_range(0, 3)) begin
      clock_ms += $urandom_range(1, 400);
      add_tick(1'b0, $urandom_range(0, 5) == 0, 4'($urandom_range(0, 14)),
               frame_at($urandom_range(0, 2)), frame_at($urandom_range(0, 2)), clock_ms);
    end
    repeat ($urandom_range(1, 3)) begin
      swap = $urandom_range(0, 1);
      clock_ms += $urandom_range(1, 400);
      add_tick(1'b0, 1'b0, 4'hF, frame_at(swap ? $urandom_range(0, 2) : 2),
               frame_at(swap ? 2 : $urandom_range(0, 2)), clock_ms);
    end
    step = (cfg_dwell >> 2) + $urandom_range(0, 300);
    repeat ($urandom_range(3, 10)) begin
      clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, step) : step;
      add_tick(1'b0, $urandom_range(0, 15) == 0, 4'hF, frame_at(0),
               frame_at(($urandom_range(0, 3) == 0) ? 1 : 0), clock_ms);
    end
    repeat ($urandom_range(0, 3)) begin
      clock_ms += step;
      add_tick(1'b0, 1'b0, 4'hF, frame_at(1), frame_at($urandom_range(0, 1)), clock_ms);
    end
    repeat ($urandom_range(0, 2)) begin
      clock_ms += $urandom_range(1, 400);
      add_tick(1'b0, $urandom_range(0, 3) == 0, 4'hF, frame_at(2),
               frame_at($urandom_range(0, 2)), clock_ms);
    end
  endtask

  // Lifting off: all legs rise while the lights go out one after another,
  // with time steps that straddle the hold time.
  task automatic unlevel_episode();
    logic [31:0] step;
    logic [3:0]  lt;
    lt   = 4'hF;
    step = (cfg_hold >> 2) + $urandom_range(0, 200);
    repeat ($urandom_range(1, 2)) begin
      clock_ms += $urandom_range(1, 400);
      add_tick(1'b1, $urandom_range(0, 1), lt, $urandom(), $urandom(), clock_ms);
    end
    repeat ($urandom_range(4, 12)) begin
      case ($urandom_range(0, 5))
        0, 1, 2: lt[$urandom_range(0, 3)] = 1'b0;
        3:       lt[$urandom_range(0, 3)] = 1'b1;
        default: ;
      endcase
      clock_ms += ($urandom_range(0, 2) == 0) ? $urandom_range(0, step) : step;
      add_tick($urandom_range(0, 7) != 0, $urandom_range(0, 1), lt, $urandom(), $urandom(),
               clock_ms);
    end
  endtask

  task automatic random_ticks(int count);
    int stop_at;
    stop_at = item_count + count;
    while (item_count < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: level_episode();
        5, 6, 7:       unlevel_episode();
        default: begin
          // Unstructured ticks: every field random, time jumping anywhere.
          repeat ($urandom_range(1, 6)) begin
            add_tick($urandom_range(0, 1), $urandom_range(0, 1), 4'($urandom_range(0, 15)),
                     $urandom(), $urandom(), $urandom());
          end
        end
      endcase
    end
  endtask

  // Directed ticks under the reset settings (set point 0, tolerance 100,
  // dwell 2000 ms, hold 10000 ms).
  task automatic directed_ticks();
    add_tick(1'b1, 1'b0, 4'hF, '0, '0, 32'd0);                   // unlevel, all lit
    add_tick(1'b0, 1'b0, 4'h0, 32'hFFFF_FFFF, '0, 32'd10);       // seek, x dominates
    add_tick(1'b0, 1'b0, 4'b0101, '0, 32'hFFFF_FFFF, 32'd20);    // seek, y dominates
    add_tick(1'b0, 1'b0, 4'b1010, '0, '0, 32'd30);               // seek, tie at zero
    add_tick(1'b0, 1'b0, 4'hF, frame_of(150), frame_of(0), 32'd40);
    add_tick(1'b0, 1'b0, 4'hF, '0, '0, 32'd1000);                // enters level
    // Errors on the window edge; dwell exactly reached but not exceeded.
    add_tick(1'b0, 1'b0, 4'hF, frame_of(100), frame_of(100), 32'd3000);
    // Twice the tolerance still holds level; dwell now exceeded.
    add_tick(1'b0, 1'b0, 4'hF, frame_of(200), frame_of(30), 32'd3001);
    add_tick(1'b0, 1'b0, 4'hF, frame_of(30), frame_of(201), 32'd3500);  // leaves level
    add_tick(1'b0, 1'b1, 4'hF, '0, '0, 32'd3600);                // restart in window
    add_tick(1'b0, 1'b0, 4'hF, frame_of(101), '0, 32'd6000);     // hysteresis band
    add_tick(1'b0, 1'b1, 4'hF, frame_of(101), '0, 32'd6100);     // restart drops level
    add_tick(1'b1, 1'b1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7000);
    add_tick(1'b1, 1'b0, 4'b1110, '0, '0, 32'd8000);             // leg 0 just went off
    add_tick(1'b1, 1'b0, 4'b1110, '0, '0, 32'd17999);            // one ms short of hold
    add_tick(1'b1, 1'b0, 4'b1100, '0, '0, 32'd18000);            // hold expires
    add_tick(1'b1, 1'b0, 4'b0000, '0, '0, 32'hFFFF_FFFF);
    add_tick(1'b1, 1'b0, 4'b0000, '0, '0, 32'd100);              // timer wraps
    add_tick(1'b0, 1'b0, 4'hF, frame_of(MaxAngle), frame_of(MaxAngle), 32'd200);
    add_tick(1'b0, 1'b0, 4'h0, '0, frame_of(5), 32'd300);
    add_tick(1'b1, 1'b0, 4'hF, '0, '0, 32'd400);                 // lights back on
  endtask

  // Register writes happen only while the block is idle, so the shadow is
  // updated together with the write.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_SET_POINT:  cfg_set_point = value[AngleW-1:0];
      CFG_TOLERANCE:  cfg_tolerance = value[AngleW-1:0];
      CFG_DWELL_TIME: cfg_dwell     = value;
      default:        cfg_hold      = value;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [CfgW-1:0] sp, logic [CfgW-1:0] tl, logic [CfgW-1:0] dw,
                            logic [CfgW-1:0] hd);
    write_reg(CFG_SET_POINT, sp);
    write_reg(CFG_TOLERANCE, tl);
    write_reg(CFG_DWELL_TIME, dw);
    write_reg(CFG_UNLEVEL_HOLD, hd);
  endtask

  // Waits until every queued tick has gone in and every result has come
  // back, then lets the two pipeline stages settle. The check runs just
  // after the falling edge so that the driver's update is already visible.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
      #1;
    end while (tick_q.size() != 0 || in_valid_i || drive_fifo.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: the input transaction changes on the falling edge, once the
  // previous one has been taken. Gaps come in bursts.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_data_i  <= tick_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure, in bursts as well.
  always @(negedge clk_i) begin
    if (snk_gap > 0) begin
      snk_gap--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
      snk_gap = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted input transaction and checks every
  // accepted result transaction against the oldest prediction. The watchdog
  // ends the run when nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_t got, want;
    bit   out_taken;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        drive_fifo.push_back(control_tick(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        got = out_data_o;
        if (drive_fifo.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = drive_fifo.pop_front();
          if (got.drive_s0 !== want.drive_s0)
            report_mismatch($sformatf("result %0d drive_s0 %0d, expected %0d",
                                      result_count, got.drive_s0, want.drive_s0));
          if (got.drive_s1 !== want.drive_s1)
            report_mismatch($sformatf("result %0d drive_s1 %0d, expected %0d",
                                      result_count, got.drive_s1, want.drive_s1));
          if (got.drive_s2 !== want.drive_s2)
            report_mismatch($sformatf("result %0d drive_s2 %0d, expected %0d",
                                      result_count, got.drive_s2, want.drive_s2));
          if (got.drive_s3 !== want.drive_s3)
            report_mismatch($sformatf("result %0d drive_s3 %0d, expected %0d",
                                      result_count, got.drive_s3, want.drive_s3));
          if (got.level_reached !== want.level_reached)
            report_mismatch($sformatf("result %0d level_reached %b, expected %b",
                                      result_count, got.level_reached, want.level_reached));
          if (got.ready_res !== want.ready_res)
            report_mismatch($sformatf("result %0d ready_res %b, expected %b",
                                      result_count, got.ready_res, want.ready_res));
        end
        result_count++;
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: directed ticks under the reset settings, then random
  // episodes under a series of register settings. The last phase runs
  // without gaps or stalls.
  // --------------------------------------------------------------------------
  initial begin : sequence_ctl
    src_idle_pct  = 20;
    snk_stall_pct = 20;
    clock_ms      = 32'd1000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_ticks();
    clock_ms = 32'd20000;
    random_ticks(170);
    wait_idle();

    for (int p = 1; p < Phases; p++) begin
      case (p)
        1: set_config(32'd0, 32'd0, 32'd0, 32'd0);
        2: set_config(MaxAngle, $urandom_range(1, 200), 32'd500, 32'd1000);
        3: set_config($urandom_range(0, MaxAngle), MaxAngle, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_config($urandom_range(0, MaxAngle), $urandom_range(0, 400),
                            $urandom_range(0, 4000), $urandom_range(0, 15000));
      endcase
      src_idle_pct  = (p == Phases - 1) ? 0 : pick_idle_pct();
      snk_stall_pct = (p == Phases - 1) ? 0 : pick_idle_pct();
      random_ticks(190);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
